// File: rtl/hre_pkg.sv
`timescale 1ns / 1ps
package hre_pkg;

  localparam int EdgeW = 32;
  localparam int RpmW  = 15;
  localparam int ProdW = 48;
  localparam int DenW  = 26;

  localparam logic [15:0]   MS_PER_MIN     = 16'd60000;
  localparam logic [17:0]   DISP_CAP_OTHER = 18'sd80;
  localparam logic [17:0]   SLEW_RUNNING   = 18'sd40;
  localparam logic [17:0]   UP_STEP_OTHER  = 18'sd150;
  localparam logic [17:0]   UP_STEP_START  = 18'sd40;
  localparam logic [2:0]    CODE_NONE      = 3'd0;
  localparam logic [2:0]    CODE_INVALID   = 3'd7;

  typedef enum logic [2:0] {
    OP_HALL  = 3'd0,
    OP_TICK  = 3'd1,
    OP_EN    = 3'd2,
    OP_RESET = 3'd3,
    OP_SEED  = 3'd4
  } hre_op_t;

  typedef enum logic [2:0] {
    REG_EPR   = 3'd0,
    REG_TP    = 3'd1,
    REG_RATED = 3'd2,
    REG_START = 3'd3,
    REG_FMAX  = 3'd4,
    REG_CWIN  = 3'd5,
    REG_DWIN  = 3'd6
  } hre_reg_t;

  typedef enum logic [1:0] {
    MS_OTHER    = 2'd0,
    MS_STARTING = 2'd1,
    MS_RUNNING  = 2'd2
  } hre_ms_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RAW,
    ST_DIV_CTRL,
    ST_FILT,
    ST_DIV_DISP,
    ST_OUT
  } hre_state_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MUL,
    DV_DEN,
    DV_RUN,
    DV_DONE
  } hre_div_st_t;

  typedef struct packed {
    logic [7:0]  epr;
    logic [9:0]  tp;
    logic [14:0] cap;
  } hre_div_cfg_t;

  function automatic logic [EdgeW-1:0] sat_add(input logic [EdgeW-1:0] a,
                                              input logic [EdgeW-1:0] b);
    logic [EdgeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[EdgeW] ? {EdgeW{1'b1}} : s[EdgeW-1:0];
  endfunction

  function automatic logic [RpmW-1:0] decay(input logic [RpmW-1:0] v);
    return (v == '0) ? v : v - {2'b00, v[RpmW-1:2]} - RpmW'(1);
  endfunction

endpackage

// File: rtl/hre_div.sv
`timescale 1ns / 1ps
// edges * 60000 / (tp * epr * ticks), capped; restoring divide, one bit a cycle
module hre_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [hre_pkg::EdgeW-1:0]    num,
  input  logic [7:0]                   ticks,
  input  hre_pkg::hre_div_cfg_t        cfg,
  output logic                         done,
  output logic [hre_pkg::RpmW-1:0]     q
);

  hre_pkg::hre_div_st_t st_r, st_nxt;
  logic [hre_pkg::EdgeW-1:0] num_r;
  logic [7:0]                ticks_r;
  logic [hre_pkg::ProdW-1:0] nq_r;
  logic [17:0]               den1_r;
  logic [hre_pkg::DenW-1:0]  den_r;
  logic [hre_pkg::DenW-1:0]  rem_r;
  logic [5:0]                cnt_r;
  logic [hre_pkg::DenW:0]    rem_sh;
  logic [hre_pkg::DenW:0]    rem_sub;
  logic [7:0]                epr_e, ticks_e;
  logic [9:0]                tp_e;

  assign epr_e   = (cfg.epr == '0) ? 8'd1 : cfg.epr;
  assign tp_e    = (cfg.tp == '0) ? 10'd1 : cfg.tp;
  assign ticks_e = (ticks_r == '0) ? 8'd1 : ticks_r;
  assign rem_sh  = {rem_r, nq_r[hre_pkg::ProdW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      hre_pkg::DV_IDLE: if (start) st_nxt = hre_pkg::DV_MUL;
      hre_pkg::DV_MUL:  st_nxt = hre_pkg::DV_DEN;
      hre_pkg::DV_DEN:  st_nxt = hre_pkg::DV_RUN;
      hre_pkg::DV_RUN:  if (cnt_r == 6'(hre_pkg::ProdW - 1)) st_nxt = hre_pkg::DV_DONE;
      // a new divide may start in the cycle the previous quotient is taken
      hre_pkg::DV_DONE: st_nxt = start ? hre_pkg::DV_MUL : hre_pkg::DV_IDLE;
      default:          st_nxt = hre_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hre_pkg::DV_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      hre_pkg::DV_IDLE, hre_pkg::DV_DONE: begin
        num_r   <= num;
        ticks_r <= ticks;
      end
      hre_pkg::DV_MUL: begin
        nq_r   <= num_r * hre_pkg::MS_PER_MIN;
        den1_r <= tp_e * epr_e;
      end
      hre_pkg::DV_DEN: begin
        den_r <= hre_pkg::DenW'(den1_r * ticks_e);
        rem_r <= '0;
        cnt_r <= '0;
      end
      hre_pkg::DV_RUN: begin
        cnt_r <= cnt_r + 6'd1;
        if (!rem_sub[hre_pkg::DenW]) begin
          rem_r <= rem_sub[hre_pkg::DenW-1:0];
          nq_r  <= {nq_r[hre_pkg::ProdW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[hre_pkg::DenW-1:0];
          nq_r  <= {nq_r[hre_pkg::ProdW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign done = (st_r == hre_pkg::DV_DONE);
  assign q    = (nq_r > hre_pkg::ProdW'(cfg.cap)) ? cfg.cap : nq_r[hre_pkg::RpmW-1:0];

endmodule

// File: rtl/hall_rpm_estimator_top.sv
`timescale 1ns / 1ps
// channel | dir | handshake            | payload
// in_     | in  | in_valid / in_ready   | operation, hall_code, motor_state, hall_enable, seed_rpm
// out_    | out | out_valid / out_ready | rpm_filtered, rpm_unfiltered, rpm_for_display, ...
// cfg_    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
// Non-tick items and disabled ticks go from idle straight to the output state. An enabled
// tick runs up to three divides (raw, control window, display window) one after another in
// the shared divider before it reaches the output state.
// rst_n is synchronous; registers return to their defaults, except ms_r, edges_r, raw_tmp_r
// and the output registers. A held result stalls the block in its output state.
module hall_rpm_estimator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [2:0]  in_hall_code,
  input  logic [1:0]  in_motor_state,
  input  logic        in_hall_enable,
  input  logic signed [15:0] in_seed_rpm,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] out_rpm_filtered,
  output logic [14:0] out_rpm_unfiltered,
  output logic [14:0] out_rpm_for_display,
  output logic        out_edge_counted,
  output logic        out_counting_enabled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  hre_pkg::hre_state_t state_r, state_nxt;

  logic [7:0]  epr_r, cwin_r, dwin_r;
  logic [9:0]  tp_r;
  logic [14:0] rated_r, scap_r, fmax_r;

  logic [31:0] win_r, edges_r, csum_r, dsum_r;
  logic [7:0]  ccnt_r, dcnt_r;
  logic [2:0]  last_r;
  logic        last_valid_r, en_r, counted_r;
  logic [14:0] raw_r, filt_r, disp_r, raw_tmp_r;
  logic [1:0]  ms_r;

  logic        out_valid_r;
  logic [14:0] o_filt_r, o_raw_r, o_disp_r;
  logic        o_cnt_r, o_en_r;

  logic                  div_go, div_done;
  logic [31:0]           div_num;
  logic [7:0]            div_ticks;
  logic [14:0]           div_q;
  hre_pkg::hre_div_cfg_t div_cfg;

  logic        accept, running, starting, out_free;
  logic [31:0] csum_new, dsum_new;
  logic [7:0]  ccnt_new, dcnt_new;
  logic        creach, dreach, hall_ok;
  logic signed [17:0] f, r, d, lim, rl, fn, fmax_s;
  logic [14:0] filt_fin, raw_fin;
  logic signed [17:0] r2, dd, dcap, dn;
  logic [14:0] disp_fin;
  logic signed [17:0] seed_c;

  assign accept   = in_valid && in_ready;
  assign running  = (ms_r == hre_pkg::MS_RUNNING);
  assign starting = (ms_r == hre_pkg::MS_STARTING);
  assign out_free = !out_valid_r || out_ready;

  assign csum_new = hre_pkg::sat_add(csum_r, edges_r);
  assign dsum_new = hre_pkg::sat_add(dsum_r, edges_r);
  assign ccnt_new = ccnt_r + 8'd1;
  assign dcnt_new = dcnt_r + 8'd1;
  assign creach   = (ccnt_new >= cwin_r);
  assign dreach   = (dcnt_new >= dwin_r);
  assign hall_ok  = en_r && (in_hall_code != hre_pkg::CODE_NONE) &&
                    (in_hall_code != hre_pkg::CODE_INVALID) &&
                    (!last_valid_r || (in_hall_code != last_r));

  assign div_cfg = '{epr: epr_r, tp: tp_r, cap: rated_r};

  hre_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (div_num),
    .ticks (div_ticks),
    .cfg   (div_cfg),
    .done  (div_done),
    .q     (div_q)
  );

  // control filter
  always_comb begin
    fmax_s = {3'b000, fmax_r};
    f  = {3'b000, filt_r};
    r  = {3'b000, raw_tmp_r};
    d  = r - f;
    lim = '0;
    rl = r;
    if (running) begin
      if (d > $signed(hre_pkg::SLEW_RUNNING)) d = hre_pkg::SLEW_RUNNING;
      else if (d < -$signed(hre_pkg::SLEW_RUNNING)) d = -$signed(hre_pkg::SLEW_RUNNING);
      fn = f + (d >>> 2);
    end else if (r > f) begin
      lim = f + (starting ? hre_pkg::UP_STEP_START : hre_pkg::UP_STEP_OTHER);
      if (r > lim) rl = lim;
      fn = f + ((rl - f) >>> 2);
    end else begin
      fn = f + (d >>> 1);
    end
    if (fn > fmax_s) fn = fmax_s;
    else if (fn < 0) fn = '0;
    filt_fin = fn[14:0];
    raw_fin  = rl[14:0];
  end

  // display filter
  always_comb begin
    r2 = {3'b000, div_q};
    if (starting && (div_q > scap_r)) r2 = {3'b000, scap_r};
    dcap = running ? hre_pkg::SLEW_RUNNING : hre_pkg::DISP_CAP_OTHER;
    dd = r2 - $signed({3'b000, disp_r});
    if (dd > dcap) dd = dcap;
    else if (dd < -dcap) dd = -dcap;
    dn = $signed({3'b000, disp_r}) + (dd >>> 3);
    if (dn > $signed({3'b000, fmax_r})) dn = {3'b000, fmax_r};
    else if (dn < 0) dn = '0;
    disp_fin = dn[14:0];
  end

  always_comb begin
    seed_c = 18'(in_seed_rpm);
    if (seed_c > $signed({3'b000, fmax_r})) seed_c = {3'b000, fmax_r};
    else if (seed_c < 0) seed_c = '0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hre_pkg::ST_IDLE: begin
        if (accept) begin
          if ((in_operation == hre_pkg::OP_TICK) && en_r) state_nxt = hre_pkg::ST_DIV_RAW;
          else state_nxt = hre_pkg::ST_OUT;
        end
      end
      hre_pkg::ST_DIV_RAW: begin
        if (div_done) begin
          if (running && creach) state_nxt = hre_pkg::ST_DIV_CTRL;
          else state_nxt = hre_pkg::ST_FILT;
        end
      end
      hre_pkg::ST_DIV_CTRL: if (div_done) state_nxt = hre_pkg::ST_FILT;
      hre_pkg::ST_FILT:     state_nxt = dreach ? hre_pkg::ST_DIV_DISP : hre_pkg::ST_OUT;
      hre_pkg::ST_DIV_DISP: if (div_done) state_nxt = hre_pkg::ST_OUT;
      hre_pkg::ST_OUT:      if (out_free) state_nxt = hre_pkg::ST_IDLE;
      default:              state_nxt = hre_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state_r == hre_pkg::ST_IDLE);
    cfg_ready = 1'b1;
    div_go    = 1'b0;
    div_num   = win_r;
    div_ticks = 8'd1;
    unique case (state_r)
      hre_pkg::ST_IDLE: begin
        div_go = accept && (in_operation == hre_pkg::OP_TICK) && en_r;
      end
      hre_pkg::ST_DIV_RAW: begin
        div_go    = div_done && running && creach;
        div_num   = csum_new;
        div_ticks = cwin_r;
      end
      hre_pkg::ST_FILT: begin
        div_go    = dreach;
        div_num   = dsum_new;
        div_ticks = dwin_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hre_pkg::ST_IDLE;
      epr_r   <= 8'd6;
      tp_r    <= 10'd10;
      rated_r <= 15'd4000;
      scap_r  <= 15'd1000;
      fmax_r  <= 15'd4000;
      cwin_r  <= 8'd3;
      dwin_r  <= 8'd5;
      win_r   <= '0;
      csum_r  <= '0;
      dsum_r  <= '0;
      ccnt_r  <= '0;
      dcnt_r  <= '0;
      last_r  <= '0;
      last_valid_r <= 1'b0;
      en_r    <= 1'b1;
      raw_r   <= '0;
      filt_r  <= '0;
      disp_r  <= '0;
      counted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == hre_pkg::ST_OUT) && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          hre_pkg::REG_EPR:   epr_r   <= cfg_data[7:0];
          hre_pkg::REG_TP:    tp_r    <= cfg_data[9:0];
          hre_pkg::REG_RATED: rated_r <= cfg_data;
          hre_pkg::REG_START: scap_r  <= cfg_data;
          hre_pkg::REG_FMAX:  fmax_r  <= cfg_data;
          hre_pkg::REG_CWIN:  cwin_r  <= cfg_data[7:0];
          hre_pkg::REG_DWIN:  dwin_r  <= cfg_data[7:0];
          default: ;
        endcase
      end

      unique case (state_r)
        hre_pkg::ST_IDLE: begin
          if (accept) begin
            counted_r <= 1'b0;
            ms_r      <= in_motor_state;
            unique case (in_operation)
              hre_pkg::OP_HALL: begin
                if (hall_ok) begin
                  win_r        <= hre_pkg::sat_add(win_r, 32'd1);
                  last_r       <= in_hall_code;
                  last_valid_r <= 1'b1;
                  counted_r    <= 1'b1;
                end
              end
              hre_pkg::OP_TICK: begin
                win_r   <= '0;
                edges_r <= win_r;
                if (!en_r) begin
                  raw_r  <= '0;
                  filt_r <= hre_pkg::decay(filt_r);
                  disp_r <= hre_pkg::decay(disp_r);
                  csum_r <= '0;
                  ccnt_r <= '0;
                  dsum_r <= '0;
                  dcnt_r <= '0;
                end
              end
              hre_pkg::OP_EN: begin
                if (!in_hall_enable) begin
                  win_r        <= '0;
                  last_valid_r <= 1'b0;
                end
                en_r <= in_hall_enable;
              end
              hre_pkg::OP_RESET: begin
                win_r  <= '0;
                raw_r  <= '0;
                filt_r <= '0;
                disp_r <= '0;
                csum_r <= '0;
                ccnt_r <= '0;
                dsum_r <= '0;
                dcnt_r <= '0;
              end
              hre_pkg::OP_SEED: begin
                raw_r  <= seed_c[14:0];
                filt_r <= seed_c[14:0];
                disp_r <= seed_c[14:0];
                csum_r <= '0;
                ccnt_r <= '0;
              end
              default: ;
            endcase
          end
        end
        hre_pkg::ST_DIV_RAW: begin
          if (div_done) begin
            if (starting) begin
              raw_tmp_r <= (div_q > scap_r) ? scap_r : div_q;
              csum_r <= '0;
              ccnt_r <= '0;
            end else if (running) begin
              if (creach) begin
                csum_r <= csum_new;
                ccnt_r <= ccnt_new;
              end else begin
                raw_tmp_r <= filt_r;
                csum_r <= csum_new;
                ccnt_r <= ccnt_new;
              end
            end else begin
              raw_tmp_r <= div_q;
              csum_r <= '0;
              ccnt_r <= '0;
            end
          end
        end
        hre_pkg::ST_DIV_CTRL: begin
          if (div_done) begin
            raw_tmp_r <= div_q;
            csum_r <= '0;
            ccnt_r <= '0;
          end
        end
        hre_pkg::ST_FILT: begin
          filt_r <= filt_fin;
          raw_r  <= raw_fin;
          dsum_r <= dsum_new;
          dcnt_r <= dcnt_new;
        end
        hre_pkg::ST_DIV_DISP: begin
          if (div_done) begin
            disp_r <= disp_fin;
            dsum_r <= '0;
            dcnt_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == hre_pkg::ST_OUT) && out_free) begin
      o_filt_r <= filt_r;
      o_raw_r  <= raw_r;
      o_disp_r <= ((raw_r < filt_r) || (raw_r < disp_r)) ? raw_r : disp_r;
      o_cnt_r  <= counted_r;
      o_en_r   <= en_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_rpm_filtered     = o_filt_r;
  assign out_rpm_unfiltered   = o_raw_r;
  assign out_rpm_for_display  = o_disp_r;
  assign out_edge_counted     = o_cnt_r;
  assign out_counting_enabled = o_en_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == hre_pkg::ST_DIV_RAW || state_r == hre_pkg::ST_DIV_CTRL ||
                  state_r == hre_pkg::ST_DIV_DISP))
    else $error("divider finished outside a divide step");

  a_filt_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hre_pkg::ST_FILT) |=> (filt_r <= fmax_r))
    else $error("filtered rpm above clamp");

  a_disabled_no_last: assert property (@(posedge clk) disable iff (!rst_n)
    !en_r |-> !last_valid_r)
    else $error("last sector valid while counting disabled");

endmodule
